FILE: rtl/les_pkg.sv
// ----------------------------------------------------------------------------
// les_pkg - shared types and constants for line edge setup
// Beat structs for both channels and the sizing of the divider pipelines.
// ----------------------------------------------------------------------------
package les_pkg;

    // input beat: one line segment
    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] given_slope;
        logic               winding_in;
    } seg_t;

    // output beat: one set-up edge
    typedef struct packed {
        logic               edge_valid;
        logic signed [31:0] top_x;
        logic signed [31:0] top_y;
        logic signed [31:0] bottom_y;
        logic signed [31:0] x_per_y;
        logic        [30:0] y_per_x;
        logic               winding_out;
    } edge_t;

    // divider pipeline sizing
    localparam int DIV_STAGES = 8;
    localparam int MAIN_RW    = 22;   // |dx| up to 2^21
    localparam int MAIN_QW    = 32;
    localparam int MAIN_STEPS = 4;
    localparam int RCP_RW     = 11;   // reciprocal index below 1024
    localparam int RCP_QW     = 24;
    localparam int RCP_STEPS  = 3;
    localparam int NSTG       = DIV_STAGES + 4;

    localparam logic [RCP_QW-1:0] RCP_NUM   = 24'h40_0000;  // 2^22
    localparam logic [30:0]       MAX_POS   = 31'h7FFF_FFFF;
    localparam logic [21:0]       INV_LIMIT = 22'd1024;
    localparam logic [21:0]       MIN_DIV   = 22'd8;
    localparam logic [21:0]       A_LIMIT   = 22'd4096;

    // side info that travels with an edge through the divider stages
    typedef struct packed {
        logic signed [31:0] top_x;
        logic signed [31:0] top_y;
        logic signed [31:0] bot_y;
        logic signed [31:0] slope;
        logic               wind;
        logic               dy_zero;
        logic               flat;
        logic               recip_path;
        logic               fast;
        logic               sat;
        logic               neg;
        logic               s_zero;
        logic        [11:0] ady12;
    } info_t;

endpackage

FILE: rtl/les_seg_if.sv
// ----------------------------------------------------------------------------
// les_seg_if - segment channel
// Valid/ready channel carrying one line segment per beat.
// ----------------------------------------------------------------------------
interface les_seg_if;
    logic          valid;
    logic          ready;
    les_pkg::seg_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/les_edge_if.sv
// ----------------------------------------------------------------------------
// les_edge_if - edge channel
// Valid/ready channel carrying one set-up edge per beat.
// ----------------------------------------------------------------------------
interface les_edge_if;
    logic           valid;
    logic           ready;
    les_pkg::edge_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/les_div_stage.sv
// ----------------------------------------------------------------------------
// les_div_stage - one stage of a pipelined restoring divider
// Retires STEPS quotient bits per stage. acc holds {remainder, numerator};
// quotient bits shift in from the bottom as numerator bits move out the top.
// ----------------------------------------------------------------------------
module les_div_stage #(
    parameter int RW    = 22,
    parameter int QW    = 32,
    parameter int STEPS = 4
) (
    input  logic             clk,
    input  logic             en,
    input  logic [RW-1:0]    dvsr_in,
    input  logic [RW+QW-1:0] acc_in,
    output logic [RW-1:0]    dvsr_out,
    output logic [RW+QW-1:0] acc_out
);

    logic [RW-1:0]    dvsr_reg;
    logic [RW+QW-1:0] acc_reg;
    logic [RW+QW-1:0] acc_next;

    // restoring steps: compare, subtract, shift
    always_comb
    begin
        logic [RW:0]   trial;
        logic [RW:0]   diff;
        logic          ge;
        logic [RW-1:0] rem;
        acc_next = acc_in;
        for (int i = 0; i < STEPS; i++)
        begin
            trial    = acc_next[RW+QW-1:QW-1];
            diff     = trial - {1'b0, dvsr_in};
            ge       = (trial >= {1'b0, dvsr_in});
            rem      = ge ? diff[RW-1:0] : trial[RW-1:0];
            acc_next = {rem, acc_next[QW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg  <= acc_next;
            dvsr_reg <= dvsr_in;
        end
    end

    assign acc_out  = acc_reg;
    assign dvsr_out = dvsr_reg;

endmodule

FILE: rtl/line_edge_setup.sv
// ----------------------------------------------------------------------------
// line_edge_setup - scanline edge setup with pipelined inverse slope
// Orders endpoints, rejects zero-height lines and derives |dy/dx| in 16.16.
//
//   channel   | dir | beat                       | handshake
//   ----------+-----+----------------------------+-------------
//   seg_in    | in  | endpoints, slope, winding  | valid/ready
//   edge_out  | out | ordered edge, inverse slope| valid/ready
//
// One edge per cycle sustained while edge_out is ready. The depth is set by
// the 8-stage restoring dividers (32 quotient bits for dy/dx, 24 for the
// 2^22/n reciprocals), plus order, setup, multiply and output stages.
// Reset clears only the stage valid bits.
// Each stage advances when it is empty or the one after it advances, so
// bubbles close up under a stall and no beat is lost or repeated.
// ----------------------------------------------------------------------------
module line_edge_setup (
    input  logic            clk,
    input  logic            rst_n,
    les_seg_if.sink         seg_in,
    les_edge_if.source      edge_out
);

    localparam int NS = les_pkg::NSTG;
    localparam int DS = les_pkg::DIV_STAGES;
    localparam int MW = les_pkg::MAIN_RW + les_pkg::MAIN_QW;
    localparam int RW = les_pkg::RCP_RW + les_pkg::RCP_QW;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] adv;

    // stall chain: a stage moves when empty or its successor moves
    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || edge_out.ready;
        for (int k = NS - 2; k >= 0; k--)
            adv[k] = !valid_reg[k] || adv[k+1];
    end

    assign seg_in.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (adv[0])
                valid_reg[0] <= seg_in.valid;
            for (int k = 1; k < NS; k++)
                if (adv[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    // stage 0: order endpoints and take 16.6 differences
    logic signed [31:0] s0_tx_reg, s0_ty_reg, s0_by_reg, s0_slope_reg;
    logic               s0_wind_reg;
    logic signed [21:0] s0_dx_reg, s0_dy_reg;
    logic               swap;
    logic signed [31:0] tx, ty, bx, by, dxw, dyw;

    always_comb
    begin
        swap = seg_in.data.start_y > seg_in.data.end_y;
        tx   = swap ? seg_in.data.end_x   : seg_in.data.start_x;
        ty   = swap ? seg_in.data.end_y   : seg_in.data.start_y;
        bx   = swap ? seg_in.data.start_x : seg_in.data.end_x;
        by   = swap ? seg_in.data.start_y : seg_in.data.end_y;
        dxw  = bx - tx;
        dyw  = by - ty;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_tx_reg    <= tx;
            s0_ty_reg    <= ty;
            s0_by_reg    <= by;
            s0_slope_reg <= seg_in.data.given_slope;
            s0_wind_reg  <= seg_in.data.winding_in ^ swap;
            s0_dx_reg    <= dxw[31:10];
            s0_dy_reg    <= dyw[31:10];
        end
    end

    // stage 1: magnitudes, path flags, divider seeds
    les_pkg::info_t info_next;
    les_pkg::info_t info_reg [0:DS];
    logic [21:0] adx, ady, s_abs;
    logic signed [21:0] s_sh;
    logic [MW-1:0] m_acc1_reg;
    logic [les_pkg::MAIN_RW-1:0] m_dv1_reg;
    logic [RW-1:0] s_acc1_reg, b_acc1_reg;
    logic [les_pkg::RCP_RW-1:0] s_dv1_reg, b_dv1_reg;

    always_comb
    begin
        adx  = s0_dx_reg[21] ? 22'(-s0_dx_reg) : s0_dx_reg;
        ady  = s0_dy_reg[21] ? 22'(-s0_dy_reg) : s0_dy_reg;
        s_sh = s0_slope_reg[31:10];
        s_abs = s_sh[21] ? 22'(-s_sh) : s_sh;
        info_next.top_x   = s0_tx_reg;
        info_next.top_y   = s0_ty_reg;
        info_next.bot_y   = s0_by_reg;
        info_next.slope   = s0_slope_reg;
        info_next.wind    = s0_wind_reg;
        info_next.dy_zero = (s0_dy_reg == '0);
        info_next.flat    = (s0_dx_reg == '0) || (s0_slope_reg == '0);
        info_next.recip_path = s_abs < les_pkg::INV_LIMIT;
        info_next.fast    = (adx >= les_pkg::MIN_DIV) && (adx < les_pkg::INV_LIMIT)
                            && (ady < les_pkg::A_LIMIT);
        info_next.sat     = {15'b0, ady} >= {adx, 15'b0};
        info_next.neg     = s0_dx_reg[21] ^ s0_dy_reg[21];
        info_next.s_zero  = (s_abs == '0);
        info_next.ady12   = ady[11:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            m_acc1_reg  <= {16'b0, ady[21:16], ady[15:0], 16'b0};
            m_dv1_reg   <= adx;
            s_acc1_reg  <= {{les_pkg::RCP_RW{1'b0}}, les_pkg::RCP_NUM};
            s_dv1_reg   <= s_abs[10:0];
            b_acc1_reg  <= {{les_pkg::RCP_RW{1'b0}}, les_pkg::RCP_NUM};
            b_dv1_reg   <= adx[10:0];
        end
    end

    // stages 2..9: dy/dx divider and two reciprocal dividers
    logic [MW-1:0]               m_acc [0:DS];
    logic [les_pkg::MAIN_RW-1:0] m_dv  [0:DS];
    logic [RW-1:0]               s_acc [0:DS];
    logic [les_pkg::RCP_RW-1:0]  s_dv  [0:DS];
    logic [RW-1:0]               b_acc [0:DS];
    logic [les_pkg::RCP_RW-1:0]  b_dv  [0:DS];

    assign m_acc[0] = m_acc1_reg;
    assign m_dv[0]  = m_dv1_reg;
    assign s_acc[0] = s_acc1_reg;
    assign s_dv[0]  = s_dv1_reg;
    assign b_acc[0] = b_acc1_reg;
    assign b_dv[0]  = b_dv1_reg;

    for (genvar i = 0; i < DS; i++)
    begin : g_div
        les_div_stage #(
            .RW(les_pkg::MAIN_RW), .QW(les_pkg::MAIN_QW), .STEPS(les_pkg::MAIN_STEPS)
        ) u_main (
            .clk(clk), .en(adv[2+i]),
            .dvsr_in(m_dv[i]), .acc_in(m_acc[i]),
            .dvsr_out(m_dv[i+1]), .acc_out(m_acc[i+1])
        );
        les_div_stage #(
            .RW(les_pkg::RCP_RW), .QW(les_pkg::RCP_QW), .STEPS(les_pkg::RCP_STEPS)
        ) u_rcp_s (
            .clk(clk), .en(adv[2+i]),
            .dvsr_in(s_dv[i]), .acc_in(s_acc[i]),
            .dvsr_out(s_dv[i+1]), .acc_out(s_acc[i+1])
        );
        les_div_stage #(
            .RW(les_pkg::RCP_RW), .QW(les_pkg::RCP_QW), .STEPS(les_pkg::RCP_STEPS)
        ) u_rcp_b (
            .clk(clk), .en(adv[2+i]),
            .dvsr_in(b_dv[i]), .acc_in(b_acc[i]),
            .dvsr_out(b_dv[i+1]), .acc_out(b_acc[i+1])
        );
    end

    // side info shift register, stage 1 through the last divider stage
    always_ff @(posedge clk)
    begin
        if (adv[1])
            info_reg[0] <= info_next;
        for (int i = 0; i < DS; i++)
            if (adv[2+i])
                info_reg[i+1] <= info_reg[i];
    end

    // stage 10: fast-path product and quotient pick-up
    les_pkg::info_t s10_info_reg;
    logic [31:0]    s10_prod_reg;
    logic [30:0]    s10_rs_reg;
    logic [30:0]    s10_q_reg;

    always_ff @(posedge clk)
    begin
        if (adv[NS-2])
        begin
            s10_info_reg <= info_reg[DS];
            s10_prod_reg <= {20'b0, info_reg[DS].ady12}
                            * {12'b0, b_acc[DS][19:0]};
            s10_rs_reg   <= info_reg[DS].s_zero ? '0 : {8'b0, s_acc[DS][22:0]};
            s10_q_reg    <= m_acc[DS][30:0];
        end
    end

    // stage 11: select inverse slope, register the output beat
    les_pkg::edge_t out_next, out_reg;
    logic [31:0]    rnd;

    always_comb
    begin
        rnd = s10_info_reg.neg ? ((s10_prod_reg + 32'd63) >> 6) : (s10_prod_reg >> 6);
        out_next.winding_out = s10_info_reg.wind;
        if (s10_info_reg.dy_zero)
        begin
            out_next.edge_valid = 1'b0;
            out_next.top_x      = '0;
            out_next.top_y      = '0;
            out_next.bottom_y   = '0;
            out_next.x_per_y    = '0;
            out_next.y_per_x    = '0;
        end
        else
        begin
            out_next.edge_valid = 1'b1;
            out_next.top_x      = s10_info_reg.top_x;
            out_next.top_y      = s10_info_reg.top_y;
            out_next.bottom_y   = s10_info_reg.bot_y;
            out_next.x_per_y    = s10_info_reg.slope;
            if (s10_info_reg.flat)
                out_next.y_per_x = les_pkg::MAX_POS;
            else if (s10_info_reg.recip_path)
                out_next.y_per_x = s10_rs_reg;
            else if (s10_info_reg.fast)
                out_next.y_per_x = rnd[30:0];
            else if (s10_info_reg.sat)
                out_next.y_per_x = les_pkg::MAX_POS;
            else
                out_next.y_per_x = s10_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS-1])
            out_reg <= out_next;
    end

    assign edge_out.valid = valid_reg[NS-1];
    assign edge_out.data  = out_reg;

endmodule

FILE: rtl/les_checker.sv
// ----------------------------------------------------------------------------
// les_checker - port-level checks for line_edge_setup
// Watches both channels; bound to the top level below.
// ----------------------------------------------------------------------------
module les_checker (
    input  logic        clk,
    input  logic        rst_n,
    les_seg_if.sink     seg_in,
    les_edge_if.source  edge_out
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        edge_out.valid && !edge_out.ready |=> edge_out.valid && $stable(edge_out.data))
        else $error("output beat changed under stall");

    // rejected edges carry zeros
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        edge_out.valid && !edge_out.data.edge_valid |->
        edge_out.data.top_x == '0 && edge_out.data.bottom_y == '0 &&
        edge_out.data.x_per_y == '0 && edge_out.data.y_per_x == '0)
        else $error("rejected edge with nonzero fields");

    // endpoints come out ordered
    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        edge_out.valid && edge_out.data.edge_valid |->
        edge_out.data.top_y < edge_out.data.bottom_y)
        else $error("edge endpoints not ordered");

    // zero slope gives the maximum inverse slope
    a_flat_max: assert property (@(posedge clk) disable iff (!rst_n)
        edge_out.valid && edge_out.data.edge_valid && edge_out.data.x_per_y == '0 |->
        edge_out.data.y_per_x == 31'h7FFF_FFFF)
        else $error("zero slope without saturated inverse");

    // nothing leaves while reset is held
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !edge_out.valid)
        else $error("output valid during reset");

endmodule

bind line_edge_setup les_checker u_les_checker (
    .clk(clk),
    .rst_n(rst_n),
    .seg_in(seg_in),
    .edge_out(edge_out)
);
